[rtl/cursor_gap_buffer_editor_macros.svh]
`ifndef CURSOR_GAP_BUFFER_EDITOR_MACROS_SVH
`define CURSOR_GAP_BUFFER_EDITOR_MACROS_SVH

// Same-cycle implication, sampled at the rising edge of clk outside reset.
`define CGBE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgbe assertion failed");

// Next-cycle implication, sampled at the rising edge of clk outside reset.
`define CGBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgbe assertion failed");

`endif

[rtl/cgbe_pkg.sv]
package cgbe_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_LEFT   = 3'd1;
	localparam logic [2:0] CMD_RIGHT  = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_DUMP   = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EDGE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_in;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic [1:0] status;
		logic       last;
	} rsp_t;

endpackage

[rtl/cgbe_ram.sv]
module cgbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/cursor_gap_buffer_editor.sv]
// Line-editing buffer with a cursor, kept as two stacks in one single-port
// memory of CAPACITY bytes. A command is taken when start is high and busy is
// low. Insert, delete and any refused command give their result strobe in the
// next cycle. A cursor move passes through S_MOVE, because the byte is read
// from one stack and then written to the other through the same memory port.
// A dump of n bytes reads one byte per cycle and holds busy in S_DUMP until
// its last byte is read, giving n result beats on consecutive cycles, the
// last one marked, and then empties the buffer. Result beats are shown for
// exactly one cycle and cannot be stalled.
module cursor_gap_buffer_editor #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cgbe_pkg::req_t req,
	output logic          busy,
	output logic          rsp_valid,
	output cgbe_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [CW:0] CAP_T = (CW + 1)'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOVE = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] right_q;
	logic [CW-1:0] pos_q;
	logic          dir_left_q;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic          dvalid_s1;
	logic          dlast_s1;

	logic          accept;
	logic [CW:0]   total;
	logic          full;
	logic [CW-1:0] dpos;
	logic [CW:0]   dsum;
	logic          dlast;
	logic [CW:0]   rtop;
	logic [CW:0]   rnext;
	logic [CW-1:0] lprev;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign total  = {1'b0, left_q} + {1'b0, right_q};
	assign full   = (total >= CAP_T);
	assign dpos   = (state_q == S_DUMP) ? pos_q : '0;
	assign dsum   = (dpos < left_q) ? {1'b0, dpos} : ({1'b0, dpos} + (CAP_T - total));
	assign dlast  = (({1'b0, dpos} + (CW + 1)'(1)) == total);
	assign rtop   = CAP_T - {1'b0, right_q};
	assign rnext  = rtop - (CW + 1)'(1);
	assign lprev  = left_q - CW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = left_q[AW-1:0];
		ram_wdata = req.char_in;
		case (state_q)
			S_IDLE: begin
				case (req.req_type)
					cgbe_pkg::CMD_INSERT: ram_we = accept && !full;
					cgbe_pkg::CMD_LEFT:   ram_addr = lprev[AW-1:0];
					cgbe_pkg::CMD_RIGHT:  ram_addr = rtop[AW-1:0];
					cgbe_pkg::CMD_DUMP:   ram_addr = dsum[AW-1:0];
					default:              ram_addr = left_q[AW-1:0];
				endcase
			end
			S_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_addr  = dir_left_q ? rnext[AW-1:0] : left_q[AW-1:0];
			end
			S_DUMP: ram_addr = dsum[AW-1:0];
			default: ram_addr = left_q[AW-1:0];
		endcase
	end

	cgbe_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			left_q      <= '0;
			right_q     <= '0;
			pos_q       <= '0;
			dir_left_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			status_q    <= cgbe_pkg::ST_DONE;
			dvalid_s1   <= 1'b0;
			dlast_s1    <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			dvalid_s1   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.req_type)
							cgbe_pkg::CMD_INSERT: begin
								rsp_valid_q <= 1'b1;
								if (full) begin
									status_q <= cgbe_pkg::ST_FULL;
								end else begin
									status_q <= cgbe_pkg::ST_DONE;
									left_q   <= left_q + CW'(1);
								end
							end
							cgbe_pkg::CMD_LEFT: begin
								if (left_q == '0) begin
									rsp_valid_q <= 1'b1;
									status_q    <= cgbe_pkg::ST_EDGE;
								end else begin
									dir_left_q <= 1'b1;
									state_q    <= S_MOVE;
								end
							end
							cgbe_pkg::CMD_RIGHT: begin
								if (right_q == '0) begin
									rsp_valid_q <= 1'b1;
									status_q    <= cgbe_pkg::ST_EDGE;
								end else begin
									dir_left_q <= 1'b0;
									state_q    <= S_MOVE;
								end
							end
							cgbe_pkg::CMD_DELETE: begin
								rsp_valid_q <= 1'b1;
								if (left_q == '0) begin
									status_q <= cgbe_pkg::ST_EDGE;
								end else begin
									status_q <= cgbe_pkg::ST_DONE;
									left_q   <= lprev;
								end
							end
							cgbe_pkg::CMD_DUMP: begin
								if (total == '0) begin
									rsp_valid_q <= 1'b1;
									status_q    <= cgbe_pkg::ST_EMPTY;
								end else begin
									dvalid_s1 <= 1'b1;
									dlast_s1  <= dlast;
									pos_q     <= CW'(1);
									if (dlast) begin
										left_q  <= '0;
										right_q <= '0;
									end else begin
										state_q <= S_DUMP;
									end
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
								status_q    <= cgbe_pkg::ST_EDGE;
							end
						endcase
					end
				end
				S_MOVE: begin
					rsp_valid_q <= 1'b1;
					status_q    <= cgbe_pkg::ST_DONE;
					state_q     <= S_IDLE;
					if (dir_left_q) begin
						left_q  <= lprev;
						right_q <= right_q + CW'(1);
					end else begin
						left_q  <= left_q + CW'(1);
						right_q <= right_q - CW'(1);
					end
				end
				S_DUMP: begin
					dvalid_s1 <= 1'b1;
					dlast_s1  <= dlast;
					pos_q     <= pos_q + CW'(1);
					if (dlast) begin
						left_q  <= '0;
						right_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q || dvalid_s1;
	assign rsp.char_out = dvalid_s1 ? ram_rdata : 8'd0;
	assign rsp.status   = dvalid_s1 ? cgbe_pkg::ST_DONE : status_q;
	assign rsp.last     = dvalid_s1 ? dlast_s1 : 1'b1;

endmodule

[rtl/cgbe_checker.sv]
`include "cursor_gap_buffer_editor_macros.svh"

module cgbe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input cgbe_pkg::req_t req,
	input logic           rsp_valid,
	input cgbe_pkg::rsp_t rsp
);

	logic take;
	logic take_insert;
	logic take_dump;
	logic insert_beat_ok;
	logic beat_more;

	assign take           = start && !busy;
	assign take_insert    = take && (req.req_type == cgbe_pkg::CMD_INSERT);
	assign take_dump      = take && (req.req_type == cgbe_pkg::CMD_DUMP);
	assign insert_beat_ok = rsp_valid && rsp.last
		&& (rsp.status == cgbe_pkg::ST_DONE || rsp.status == cgbe_pkg::ST_FULL);
	assign beat_more      = rsp_valid && !rsp.last;

	// An insert always answers with a single final beat in the next cycle.
	`CGBE_ASSERT_NEXT(a_insert_answer, take_insert, insert_beat_ok)

	// A dump either answers at once or keeps the block busy while it streams.
	`CGBE_ASSERT_NEXT(a_dump_start, take_dump, rsp_valid || busy)

	// Dump beats before the last one come back to back.
	`CGBE_ASSERT_NEXT(a_dump_stream, beat_more, rsp_valid)

	// While a dump still has beats to send, no new command is taken.
	`CGBE_ASSERT_SAME(a_dump_busy, beat_more, busy)

endmodule

bind cursor_gap_buffer_editor cgbe_checker u_cgbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp      (rsp)
);
